// ----- src/rcpip_pkg.sv -----
// ============================================================================
// rcpip_pkg: shared types and constants for the ray crossing point test
// Command and status structs between controller and datapath, state codes
// and the fixed widths of the edge and result fields.
// ============================================================================
`default_nettype none

package rcpip_pkg;

    // field widths fixed by the interface
    localparam int CoordW   = 32;
    localparam int DirW     = 18;
    localparam int DiffW    = 33;
    localparam int QuotW    = 34;
    localparam int EpsLsb   = 7;

    // edge classification codes
    typedef enum logic [1:0] {
        RES_MISS = 2'd0,
        RES_HIT  = 2'd1,
        RES_NEAR = 2'd2
    } edge_res_t;

    // register indexes on the configuration port
    localparam logic [2:0] REG_DIR_X = 3'd0;
    localparam logic [2:0] REG_DIR_Y = 3'd1;
    localparam logic [2:0] REG_PT_X  = 3'd2;
    localparam logic [2:0] REG_PT_Y  = 3'd3;
    localparam logic [2:0] REG_CHK   = 3'd4;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_PICK,
        ST_DIV0,
        ST_DIV1,
        ST_CLASS,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic sum;
        logic div_start;
        logic div_sel;
        logic classify;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic parallel_miss;
        logic parallel;
        logic div_done;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- src/rcpip_div.sv -----
// ============================================================================
// rcpip_div: restoring divider for the edge quotients
// Signed 98-bit dividend by signed 64-bit divisor, one quotient bit per cycle
// over 34 bits, truncated toward zero and saturated to 32-bit signed.
// ============================================================================
`default_nettype none

module rcpip_div #(
    parameter int NUM_W = 98,
    parameter int DEN_W = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic signed [DEN_W-1:0]  den,
    output logic                          done,
    output logic signed [31:0]            quot
);
    import rcpip_pkg::*;

    localparam int CNT_W = $clog2(QuotW + 1);

    logic [NUM_W-1:0]       rem_reg, rem_next;
    logic [DEN_W-1:0]       dm_reg, dm_next;
    logic [QuotW-1:0]       q_reg, q_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   neg_reg, neg_next;
    logic                   zero_reg, zero_next;
    logic                   nneg_reg, nneg_next;
    logic                   done_reg, done_next;
    logic [NUM_W+QuotW-1:0] trial;
    logic signed [31:0]     quot_reg, quot_next;
    logic [NUM_W-1:0]       nmag;
    logic [DEN_W-1:0]       dmag;

    // magnitudes of the operands
    always_comb
    begin
        nmag = num[NUM_W-1] ? (~num + 1'b1) : num;
        dmag = den[DEN_W-1] ? (~den + 1'b1) : den;
    end

    // one quotient bit per cycle, most significant first
    always_comb
    begin
        rem_next  = rem_reg;
        dm_next   = dm_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        nneg_next = nneg_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        trial     = {{(NUM_W+QuotW-DEN_W){1'b0}}, dm_reg} << cnt_reg;
        if (start)
        begin
            rem_next  = nmag;
            dm_next   = dmag;
            q_next    = '0;
            cnt_next  = CNT_W'(QuotW - 1);
            busy_next = 1'b1;
            neg_next  = num[NUM_W-1] ^ den[DEN_W-1];
            zero_next = (dmag == '0);
            nneg_next = num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            if (!zero_reg && trial <= {{QuotW{1'b0}}, rem_reg})
            begin
                rem_next = rem_reg - trial[NUM_W-1:0];
                q_next   = q_reg | (QuotW'(1) << cnt_reg);
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                    quot_next = (rem_reg == '0) ? 32'sd0 :
                                (nneg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
                else if (neg_reg)
                    quot_next = (q_next >= QuotW'(34'h0_8000_0000)) ? 32'sh8000_0000
                                : 32'(-$signed({1'b0, q_next}));
                else
                    quot_next = (q_next > QuotW'(34'h0_7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                : 32'(q_next);
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dm_reg   <= dm_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        nneg_reg <= nneg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef SYNTH
    // done only follows a running division
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without running");
    // count stays in range while busy
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg < CNT_W'(QuotW))
        else $error("divider count out of range");
    // no done and busy together
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
`endif

endmodule

`default_nettype wire

// ----- src/rcpip_dp.sv -----
// ============================================================================
// rcpip_dp: datapath of the ray crossing point test
// Differences, registered products, determinant and cross terms, the two
// quotients through a shared divider, classification and the hit count.
// ============================================================================
`default_nettype none

module rcpip_dp #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rcpip_pkg::dp_cmd_t      cmd,
    output rcpip_pkg::dp_sts_t           sts,
    input  wire logic signed [17:0]      dir_x,
    input  wire logic signed [17:0]      dir_y,
    input  wire logic signed [31:0]      pt_x,
    input  wire logic signed [31:0]      pt_y,
    input  wire logic                    chk,
    input  wire logic signed [31:0]      sx,
    input  wire logic signed [31:0]      sy,
    input  wire logic signed [31:0]      ex,
    input  wire logic signed [31:0]      ey,
    input  wire logic                    last,
    output logic [1:0]                   res_code,
    output logic [15:0]                  res_count,
    output logic                         res_last,
    output logic                         res_outside,
    output logic                         res_unknown
);
    import rcpip_pkg::*;

    localparam int NUM_W = 66 + FRAC_BITS + 1;
    localparam int PW    = 52;
    localparam logic signed [63:0] Eps   = 64'sd7;
    localparam logic signed [63:0] Eps2  = 64'sd7 <<< FRAC_BITS;
    localparam logic signed [63:0] One   = 64'sd1 <<< FRAC_BITS;

    logic signed [31:0]      sx_reg, sy_reg, ex_reg, ey_reg;
    logic                    last_reg;
    logic signed [DiffW-1:0] a12_reg, a22_reg, b1_reg, b2_reg;
    logic signed [PW-1:0]    p11_reg, p12_reg, p21_reg, p22_reg, p31_reg, p32_reg;
    logic signed [65:0]      m1_reg, m2_reg;
    logic signed [63:0]      det_reg, d2_reg, cr_reg;
    logic signed [66:0]      d1_reg;
    logic                    usex_reg;
    logic                    par, pmiss;
    logic                    qsel_reg;
    logic signed [31:0]      q0_reg, q1_reg;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                    near_reg, near_next;
    logic [1:0]              code_reg, code_next;
    logic [1:0]              ocode_reg;
    logic [15:0]             ocount_reg;
    logic                    olast_reg, oout_reg, ounk_reg;
    logic signed [NUM_W-1:0] div_num;
    logic signed [63:0]      div_den;
    logic                    div_done;
    logic signed [31:0]      div_q;
    logic signed [63:0]      ta, tb, lo, hi;
    logic signed [63:0]      absdet, abscr;
    logic signed [DiffW:0]   num_a, num_b;

    // capture the edge
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg   <= sx;
            sy_reg   <= sy;
            ex_reg   <= ex;
            ey_reg   <= ey;
            last_reg <= last;
        end
    end

    // exact differences
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            a12_reg <= DiffW'(sx_reg) - DiffW'(ex_reg);
            a22_reg <= DiffW'(sy_reg) - DiffW'(ey_reg);
            b1_reg  <= DiffW'(sx_reg) - DiffW'(pt_x);
            b2_reg  <= DiffW'(sy_reg) - DiffW'(pt_y);
        end
    end

    // products with the ray direction (18 by 33) and the wide cross products
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p11_reg <= PW'(dir_x) * PW'(a22_reg);
            p12_reg <= PW'(a12_reg) * PW'(dir_y);
            p21_reg <= PW'(dir_x) * PW'(b2_reg);
            p22_reg <= PW'(dir_y) * PW'(b1_reg);
            p31_reg <= PW'(b1_reg) * PW'(dir_y);
            p32_reg <= PW'(b2_reg) * PW'(dir_x);
            m1_reg  <= 66'(b1_reg) * 66'(a22_reg);
            m2_reg  <= 66'(b2_reg) * 66'(a12_reg);
        end
    end

    // sums and parallel test
    always_comb
    begin
        absdet = (det_reg < 0) ? -det_reg : det_reg;
        abscr  = (cr_reg < 0) ? -cr_reg : cr_reg;
        par    = absdet < Eps2;
        pmiss  = abscr > Eps2;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            det_reg  <= 64'(p11_reg) - 64'(p12_reg);
            d2_reg   <= 64'(p21_reg) - 64'(p22_reg);
            cr_reg   <= 64'(p31_reg) - 64'(p32_reg);
            d1_reg   <= 67'(m1_reg) - 67'(m2_reg);
            usex_reg <= (dir_x > 18'sd7) || (dir_x < -18'sd7);
        end
    end

    // divider operands by phase
    always_comb
    begin
        num_a = usex_reg ? (DiffW+1)'(b1_reg) : (DiffW+1)'(b2_reg);
        num_b = usex_reg ? ((DiffW+1)'(b1_reg) - (DiffW+1)'(a12_reg))
                         : ((DiffW+1)'(b2_reg) - (DiffW+1)'(a22_reg));
        if (par)
        begin
            div_num = cmd.div_sel ? (NUM_W'(num_b) <<< FRAC_BITS)
                                  : (NUM_W'(num_a) <<< FRAC_BITS);
            div_den = usex_reg ? 64'(dir_x) : 64'(dir_y);
        end
        else
        begin
            div_num = cmd.div_sel ? (NUM_W'(d2_reg) <<< FRAC_BITS)
                                  : (NUM_W'(d1_reg) <<< FRAC_BITS);
            div_den = det_reg;
        end
    end

    rcpip_div #(
        .NUM_W (NUM_W),
        .DEN_W (64)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // remember which quotient the running division produces
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            qsel_reg <= cmd.div_sel;
    end

    // keep quotients
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            if (qsel_reg)
                q1_reg <= div_q;
            else
                q0_reg <= div_q;
        end
    end

    // classification
    always_comb
    begin
        ta = 64'(q0_reg);
        tb = 64'(q1_reg);
        lo = (tb < ta) ? tb : ta;
        hi = (tb < ta) ? ta : tb;
        code_next = RES_HIT;
        if (par)
        begin
            if (pmiss)
                code_next = RES_MISS;
            else if (chk && lo < Eps && lo > -Eps && hi <= Eps && hi >= -Eps)
                code_next = RES_NEAR;
            else if (lo <= -Eps && hi <= -Eps)
                code_next = RES_MISS;
        end
        else
        begin
            if (chk && ((tb < Eps && tb > -Eps) ||
                        (tb - One < Eps && tb - One > -Eps)))
                code_next = RES_NEAR;
            else if (ta < -Eps || tb < -Eps || tb > One + Eps)
                code_next = RES_MISS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.classify)
            code_reg <= code_next;
    end

    // count and verdict
    always_comb
    begin
        count_next = count_reg;
        near_next  = near_reg;
        if (code_reg == RES_HIT)
            count_next = count_reg + 1'b1;
        else if (code_reg == RES_NEAR)
            near_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            near_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            count_reg <= last_reg ? '0 : count_next;
            near_reg  <= last_reg ? 1'b0 : near_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            ocode_reg  <= code_reg;
            ocount_reg <= 16'(count_next);
            olast_reg  <= last_reg;
            oout_reg   <= last_reg && !count_next[0];
            ounk_reg   <= last_reg && near_next;
        end
    end

    assign res_code    = ocode_reg;
    assign res_count   = ocount_reg;
    assign res_last    = olast_reg;
    assign res_outside = oout_reg;
    assign res_unknown = ounk_reg;

    assign sts.parallel      = par;
    assign sts.parallel_miss = par && pmiss;
    assign sts.div_done      = div_done;

`ifndef SYNTH
    // state clears after a closing edge
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.commit) && $past(last_reg) |-> count_reg == '0 && !near_reg)
        else $error("state not cleared after last edge");
    // outside only reported on the closing edge
    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.commit) && oout_reg |-> olast_reg)
        else $error("verdict without last edge");
    // no division started in the same cycle as a commit
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_start && cmd.commit))
        else $error("division and commit together");
`endif

endmodule

`default_nettype wire

// ----- src/rcpip_ctrl.sv -----
// ============================================================================
// rcpip_ctrl: controller of the ray crossing point test
// Sequences one edge through products, up to two divisions, classification
// and result delivery through the output register.
// ============================================================================
`default_nettype none

module rcpip_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rcpip_pkg::dp_cmd_t       cmd,
    input  wire rcpip_pkg::dp_sts_t  sts
);
    import rcpip_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (sts.parallel_miss)
                    state_next = ST_CLASS;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV0;
                end
            end
            ST_DIV0:
            begin
                if (sts.div_done)
                begin
                    cmd.div_sel   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                cmd.div_sel = 1'b1;
                if (sts.div_done)
                    state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.commit  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = ovalid_reg;

`ifndef SYNTH
    // an edge is only taken when idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_DIFF)
        else $error("edge accepted outside idle");
    // a result is not overwritten while waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !ovalid_reg || out_ready)
        else $error("result overwritten");
    // commit raises the output valid
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> ovalid_reg)
        else $error("result lost");
`endif

endmodule

`default_nettype wire

// ----- src/ray_crossing_point_in_polygon.sv -----
// ============================================================================
// ray_crossing_point_in_polygon: edge by edge ray casting point test
// Top level: configuration registers, stream ports, controller and datapath.
// ============================================================================
// Each edge runs from acceptance through the four setup states DIFF, MUL,
// SUM and PICK, then two quotients of the shared restoring divider, then
// classification and the output register. An edge that is parallel to the
// ray and off its line skips the divider. One edge is in work at a time;
// the next edge is accepted while a finished result waits on the output
// register.
`default_nettype none

module ray_crossing_point_in_polygon #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y
    input  wire logic [127:0] s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // edge_result, crossings_so_far, point_outside, result_unknown, zero fill
    output logic [23:0]       m_tdata,
    output logic              m_tlast
);
    import rcpip_pkg::*;

    logic signed [17:0] dirx_reg, diry_reg;
    logic signed [31:0] ptx_reg, pty_reg;
    logic               chk_reg;
    logic               wr;
    logic [2:0]         idx;
    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic [1:0]         res_code;
    logic [15:0]        res_count;
    logic               res_last, res_outside, res_unknown;

    // register writes
    assign wr  = psel && penable && pwrite;
    assign idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirx_reg <= 18'sd65536;
            diry_reg <= '0;
            ptx_reg  <= '0;
            pty_reg  <= '0;
            chk_reg  <= 1'b1;
        end
        else if (wr)
        begin
            case (idx)
                REG_DIR_X: dirx_reg <= pwdata[17:0];
                REG_DIR_Y: diry_reg <= pwdata[17:0];
                REG_PT_X:  ptx_reg  <= pwdata;
                REG_PT_Y:  pty_reg  <= pwdata;
                REG_CHK:   chk_reg  <= pwdata[0];
                default:   ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (idx)
            REG_DIR_X: prdata = 32'(dirx_reg);
            REG_DIR_Y: prdata = 32'(diry_reg);
            REG_PT_X:  prdata = ptx_reg;
            REG_PT_Y:  prdata = pty_reg;
            REG_CHK:   prdata = {31'd0, chk_reg};
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    rcpip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rcpip_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .dir_x       (dirx_reg),
        .dir_y       (diry_reg),
        .pt_x        (ptx_reg),
        .pt_y        (pty_reg),
        .chk         (chk_reg),
        .sx          (s_tdata[31:0]),
        .sy          (s_tdata[63:32]),
        .ex          (s_tdata[95:64]),
        .ey          (s_tdata[127:96]),
        .last        (s_tlast),
        .res_code    (res_code),
        .res_count   (res_count),
        .res_last    (res_last),
        .res_outside (res_outside),
        .res_unknown (res_unknown)
    );

    assign m_tdata = {4'd0, res_unknown, res_outside, res_count, res_code};
    assign m_tlast = res_last;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ============================================================================
// tb: stream testbench for ray_crossing_point_in_polygon
// Sends polygon edges under a series of ray and point settings and checks every
// edge verdict against an in-bench fixed point predictor or typed directed rows.
// ============================================================================
`default_nettype none

module tb;
    import rcpip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ONE       = 65536;
    localparam int  PHASES    = 9;
    localparam int  PER_PHASE = 100;
    localparam int  LIMIT     = 1500000;
    localparam longint EPS    = EpsLsb;
    localparam longint EPS2   = longint'(EpsLsb) <<< 16;

    typedef struct {
        logic [1:0]  res;
        logic [15:0] cnt;
        bit          done;
        bit          outside;
        bit          unknown;
    } edge_verdict_t;

    typedef struct {
        logic [31:0] sx, sy, ex, ey;
        bit          last;
        bit          typed;
        logic [1:0]  res;
        logic [15:0] cnt;
    } edge_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y
    logic [127:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // edge_result, crossings_so_far, point_outside, result_unknown, zero fill
    logic [23:0]  m_tdata;
    logic         m_tlast;

    // predictor copy of the registers and the polygon state
    logic signed [17:0] ray_dx = 18'sd65536;
    logic signed [17:0] ray_dy = '0;
    logic signed [31:0] org_x = '0;
    logic signed [31:0] org_y = '0;
    bit                 prec_on = 1'b1;
    logic [15:0]        hit_count = '0;
    bit                 near_flag = 1'b0;

    edge_verdict_t verdict_q[$];
    int  errors = 0;
    int  edges_sent = 0;
    int  n_hit = 0, n_near = 0, n_miss = 0, n_poly = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;

    ray_crossing_point_in_polygon uut (.*);

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
    end

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    // truncating quotient, saturated to 32-bit signed
    function automatic longint sat_quot(logic signed [127:0] num, longint den);
        logic [127:0] mn, md, q;
        bit           neg;
        if (den == 0)
            return num == 0 ? 0 : (num < 0 ? -64'sd2147483648 : 64'sd2147483647);
        neg = (num < 0) != (den < 0);
        mn = num < 0 ? -num : num;
        md = den < 0 ? -den : den;
        q = mn / md;
        if (neg)
            return q >= 128'd2147483648 ? -64'sd2147483648 : -longint'(q);
        return q > 128'd2147483647 ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic logic [1:0] classify_edge(longint sx, longint sy,
                                                 longint ex, longint ey);
        longint a11, a21, a12, a22, b1, b2, det, d2, t, s, lo, hi, tmp;
        logic signed [127:0] wb1, wb2, wa12, wa22, d1;
        a11 = ray_dx;
        a21 = ray_dy;
        a12 = sx - ex;
        a22 = sy - ey;
        b1 = sx - longint'(org_x);
        b2 = sy - longint'(org_y);
        det = a11 * a22 - a12 * a21;
        d2 = a11 * b2 - a21 * b1;
        wb1 = b1;
        wb2 = b2;
        wa12 = a12;
        wa22 = a22;
        d1 = wb1 * wa22 - wb2 * wa12;
        // edge parallel to the ray
        if (abs_l(det) < EPS2)
        begin
            if (abs_l(b1 * a21 - b2 * a11) > EPS2)
                return RES_MISS;
            if (abs_l(a11) > EPS)
            begin
                lo = sat_quot(128'(signed'(b1)) <<< 16, a11);
                hi = sat_quot(128'(signed'(b1 - a12)) <<< 16, a11);
            end
            else
            begin
                lo = sat_quot(128'(signed'(b2)) <<< 16, a21);
                hi = sat_quot(128'(signed'(b2 - a22)) <<< 16, a21);
            end
            if (hi < lo)
            begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            if (prec_on && abs_l(lo) < EPS && abs_l(hi) <= EPS)
                return RES_NEAR;
            if (lo <= -EPS && hi <= -EPS)
                return RES_MISS;
            return RES_HIT;
        end
        // general crossing: ray parameter t, edge parameter s
        t = sat_quot(d1 <<< 16, det);
        s = sat_quot(128'(signed'(d2)) <<< 16, det);
        if (prec_on && (abs_l(s) < EPS || abs_l(s - ONE) < EPS))
            return RES_NEAR;
        if (t < -EPS || s < -EPS || s > ONE + EPS)
            return RES_MISS;
        return RES_HIT;
    endfunction

    // advance polygon state by one accepted edge
    function automatic edge_verdict_t judge_edge(logic [31:0] sx, logic [31:0] sy,
                                                 logic [31:0] ex, logic [31:0] ey,
                                                 bit last);
        edge_verdict_t v;
        v.res = classify_edge(longint'(signed'(sx)), longint'(signed'(sy)),
                              longint'(signed'(ex)), longint'(signed'(ey)));
        if (v.res == RES_HIT)
            hit_count = hit_count + 1'b1;
        else if (v.res == RES_NEAR)
            near_flag = 1'b1;
        v.cnt = hit_count;
        v.done = last;
        v.outside = last && !hit_count[0];
        v.unknown = last && near_flag;
        if (last)
        begin
            hit_count = '0;
            near_flag = 1'b0;
        end
        return v;
    endfunction

    // register write, setup phase then access phase
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DIR_X: ray_dx = val[17:0];
            REG_DIR_Y: ray_dy = val[17:0];
            REG_PT_X:  org_x = val;
            REG_PT_Y:  org_y = val;
            REG_CHK:   prec_on = val[0];
            default: ;
        endcase
    endtask

    task automatic set_ray(int dx, int dy, int px, int py, bit chk);
        reg_write(REG_DIR_X, dx);
        reg_write(REG_DIR_Y, dy);
        reg_write(REG_PT_X, px);
        reg_write(REG_PT_Y, py);
        reg_write(REG_CHK, {31'd0, chk});
    endtask

    task automatic wait_drained();
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // offer one edge and record its verdict once accepted
    task automatic offer_edge(edge_row_t r);
        edge_verdict_t v;
        s_tvalid <= 1'b1;
        s_tdata <= {r.ey, r.ex, r.sy, r.sx};
        s_tlast <= r.last;
        do
            @(posedge clk);
        while (!s_tready);
        v = judge_edge(r.sx, r.sy, r.ex, r.ey, r.last);
        if (r.typed)
        begin
            v.res = r.res;
            v.cnt = r.cnt;
        end
        verdict_q.push_back(v);
        edges_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // vertex mostly near the ray origin, often on whole units so ends land on the ray
    function automatic logic [31:0] pick_coord(logic [31:0] base);
        case ($urandom_range(0, 4))
            0, 1: return base + (int'($urandom_range(0, 16)) - 8) * ONE;
            2:    return base + int'($urandom_range(0, 1048576)) - 524288;
            3:    return base + (int'($urandom_range(0, 4)) - 2) * ONE
                         + int'($urandom_range(0, 32)) - 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_polygon();
        logic [31:0] vx[8], vy[8];
        int          n;
        edge_row_t   r;
        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++)
        begin
            vx[i] = pick_coord(org_x);
            vy[i] = pick_coord(org_y);
        end
        r.typed = 1'b0;
        r.res = RES_MISS;
        r.cnt = '0;
        for (int i = 0; i < n; i++)
        begin
            r.sx = vx[i];
            r.sy = vy[i];
            r.ex = vx[(i + 1) % n];
            r.ey = vy[(i + 1) % n];
            // occasionally break the chain with a random edge
            if ($urandom_range(0, 15) == 0)
            begin
                r.ex = $urandom;
                r.ey = $urandom;
            end
            r.last = (i == n - 1);
            offer_edge(r);
        end
        n_poly++;
    endtask

    task automatic send_noise();
        edge_row_t r;
        r.sx = $urandom;
        r.sy = $urandom;
        r.ex = $urandom;
        r.ey = $urandom;
        r.last = $urandom_range(0, 7) == 0;
        r.typed = 1'b0;
        r.res = RES_MISS;
        r.cnt = '0;
        offer_edge(r);
    endtask

    // directed edges under the reset ray: +x from the origin, precision on
    edge_row_t directed[12] = '{
        '{ONE, -ONE, ONE, ONE, 1'b0, 1'b1, RES_HIT, 16'd1},
        '{-ONE, -ONE, -ONE, ONE, 1'b0, 1'b1, RES_MISS, 16'd1},
        '{ONE, 0, 2*ONE, ONE, 1'b0, 1'b0, RES_MISS, 16'd0},
        '{2*ONE, 0, 3*ONE, 0, 1'b0, 1'b0, RES_MISS, 16'd0},
        '{ONE, ONE, 2*ONE, ONE, 1'b0, 1'b0, RES_MISS, 16'd0},
        '{-2*ONE, 0, -ONE, 0, 1'b0, 1'b0, RES_MISS, 16'd0},
        '{0, 0, 0, 0, 1'b0, 1'b0, RES_MISS, 16'd0},
        '{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0,
          RES_MISS, 16'd0},
        '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0,
          RES_MISS, 16'd0},
        '{ONE, -ONE, ONE, ONE, 1'b1, 1'b0, RES_MISS, 16'd0},
        '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1, 1'b0,
          RES_MISS, 16'd0},
        '{ONE, 0, ONE, ONE, 1'b1, 1'b0, RES_MISS, 16'd0}
    };

    // result side ready pattern
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_tready <= ($urandom_range(0, 3) == 0);
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        edge_verdict_t v;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result transaction %h", m_tdata);
                errors++;
            end
            else
            begin
                v = verdict_q.pop_front();
                case (v.res)
                    RES_HIT:  n_hit++;
                    RES_NEAR: n_near++;
                    default:  n_miss++;
                endcase
                if (m_tdata[1:0] !== v.res)
                begin
                    $error("edge_result expected %0d got %0d", v.res, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[17:2] !== v.cnt)
                begin
                    $error("crossings_so_far expected %0d got %0d", v.cnt,
                           m_tdata[17:2]);
                    errors++;
                end
                if (m_tlast !== v.done)
                begin
                    $error("polygon_done expected %0d got %0d", v.done, m_tlast);
                    errors++;
                end
                if (m_tdata[18] !== v.outside)
                begin
                    $error("point_outside expected %0d got %0d", v.outside,
                           m_tdata[18]);
                    errors++;
                end
                if (m_tdata[19] !== v.unknown)
                begin
                    $error("result_unknown expected %0d got %0d", v.unknown,
                           m_tdata[19]);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            offer_edge(directed[i]);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            s_tvalid <= 1'b0;
            wait_drained();
            case (ph)
                0: ;
                1: set_ray(-ONE, 0, 3 * ONE, -2 * ONE, 1'b1);
                2: set_ray(0, ONE, $urandom, $urandom, 1'b0);
                3: set_ray(46341, -46341, $urandom_range(0, 65535), 0, 1'b1);
                4: set_ray(-ONE, -ONE, 32'h7fffffff, 32'h80000000, 1'b1);
                5: set_ray(3, ONE, -5 * ONE, 7 * ONE, 1'b1);
                6: set_ray(0, 0, ONE, ONE, 1'b1);
                7: set_ray(131071, -131072, 0, 0, 1'b0);
                default:
                    set_ray(int'($urandom_range(0, 131072)) - ONE,
                            int'($urandom_range(0, 131072)) - ONE,
                            $urandom, $urandom, 1'b1);
            endcase
            // last phase runs without idling on either side
            quiet = (ph == PHASES - 1);
            if (ph == 3)
                hold_req = 1'b1;
            while (edges_sent < (ph + 1) * PER_PHASE)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_polygon();
            end
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);

        $display("%0d edges in %0d polygons over %0d ray settings", edges_sent,
                 n_poly, PHASES);
        $display("verdicts: %0d hit, %0d near, %0d miss", n_hit, n_near, n_miss);
        if (errors == 0 && verdict_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire
